// ----- design/gprce_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Gamepad report change events: shared package
// Report and event types, control numbering, hat decoding and sequencer states.
// ----------------------------------------------------------------------------
package gprce_pkg;

   localparam int NumButtons  = 14;
   localparam int NumSticks   = 4;
   localparam int NumControls = 20;
   localparam int IdWidth     = $clog2(NumControls);
   localparam int AxisWidth   = 8;
   localparam int HatWidth    = 4;

   localparam logic [IdWidth-1:0] IdStickBase = IdWidth'(NumButtons);
   localparam logic [IdWidth-1:0] IdHatDy     = IdWidth'(NumButtons + NumSticks);
   localparam logic [IdWidth-1:0] IdHatDx     = IdWidth'(NumButtons + NumSticks + 1);
   localparam logic [IdWidth-1:0] IdLast      = IdWidth'(NumControls - 1);

   localparam logic [AxisWidth-1:0] StickCentre = 8'h80;

   // Hat codes, clockwise from up.
   localparam logic [HatWidth-1:0] HatUp        = 4'd0;
   localparam logic [HatWidth-1:0] HatUpRight   = 4'd1;
   localparam logic [HatWidth-1:0] HatRight     = 4'd2;
   localparam logic [HatWidth-1:0] HatDownRight = 4'd3;
   localparam logic [HatWidth-1:0] HatDown      = 4'd4;
   localparam logic [HatWidth-1:0] HatDownLeft  = 4'd5;
   localparam logic [HatWidth-1:0] HatLeft      = 4'd6;
   localparam logic [HatWidth-1:0] HatUpLeft    = 4'd7;
   localparam logic [HatWidth-1:0] HatReleased  = 4'd8;

   typedef struct packed {
      logic [NumButtons-1:0]                buttons;
      logic [NumSticks-1:0][AxisWidth-1:0]  sticks;
      logic [HatWidth-1:0]                  hat;
   } report_type;

   typedef struct packed {
      logic [IdWidth-1:0]          control_id;
      logic                        is_axis;
      logic signed [AxisWidth-1:0] value;
   } event_type;

   typedef struct packed {
      logic      changed;
      event_type evt;
   } cmp_result_type;

   typedef struct packed {
      event_type evt;
      logic      last;
   } rsp_event_type;

   typedef struct packed {
      logic load;
      logic commit;
   } seq_ctrl_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_FLUSH
   } seq_state_type;

   function automatic logic signed [AxisWidth-1:0] hat_dy(input logic [HatWidth-1:0] code);
      logic signed [AxisWidth-1:0] dy;
      unique case (code) inside
         HatUp, HatUpRight, HatUpLeft:     dy = -8'sd1;
         HatDownRight, HatDown, HatDownLeft: dy = 8'sd1;
         default:                          dy = '0;
      endcase
      return dy;
   endfunction

   function automatic logic signed [AxisWidth-1:0] hat_dx(input logic [HatWidth-1:0] code);
      logic signed [AxisWidth-1:0] dx;
      unique case (code) inside
         HatUpRight, HatRight, HatDownRight: dx = 8'sd1;
         HatDownLeft, HatLeft, HatUpLeft:    dx = -8'sd1;
         default:                            dx = '0;
      endcase
      return dx;
   endfunction

endpackage
`default_nettype wire

// ----- design/gprce_channels.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Gamepad report change events: channel interfaces
// Valid/ready channels for incoming reports and outgoing change events.
// ----------------------------------------------------------------------------
interface gprce_req_if;
   import gprce_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [NumButtons-1:0] buttons;
   logic [AxisWidth-1:0] left_x;
   logic [AxisWidth-1:0] left_y;
   logic [AxisWidth-1:0] right_x;
   logic [AxisWidth-1:0] right_y;
   logic [HatWidth-1:0]  hat_position;

   modport source (
      output valid, buttons, left_x, left_y, right_x, right_y, hat_position,
      input  ready
   );
   modport sink (
      input  valid, buttons, left_x, left_y, right_x, right_y, hat_position,
      output ready
   );
endinterface

interface gprce_rsp_if;
   import gprce_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [IdWidth-1:0]          control_id;
   logic                        is_axis;
   logic signed [AxisWidth-1:0] value;
   logic                        last;

   modport source (
      output valid, control_id, is_axis, value, last,
      input  ready
   );
   modport sink (
      input  valid, control_id, is_axis, value, last,
      output ready
   );
endinterface
`default_nettype wire

// ----- design/gprce_cmp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Gamepad report change events: shared compare unit
// Selects one control of the old and new report by index, compares them and
// forms the event that a change of that control produces.
// ----------------------------------------------------------------------------
module gprce_cmp (
   input  wire logic [gprce_pkg::IdWidth-1:0] idx,
   input  gprce_pkg::report_type              prev_rep,
   input  gprce_pkg::report_type              cur_rep,
   output gprce_pkg::cmp_result_type          result
);
   import gprce_pkg::*;

   logic [$clog2(NumButtons)-1:0] btn_sel;
   logic [$clog2(NumSticks)-1:0]  stick_sel;
   logic [AxisWidth-1:0]          old_stick;
   logic [AxisWidth-1:0]          new_stick;
   logic                          hat_moved;
   logic signed [AxisWidth-1:0]   new_dy;
   logic signed [AxisWidth-1:0]   new_dx;

   assign btn_sel   = idx[$clog2(NumButtons)-1:0];
   assign stick_sel = $clog2(NumSticks)'(idx - IdStickBase);
   assign old_stick = prev_rep.sticks[stick_sel];
   assign new_stick = cur_rep.sticks[stick_sel];
   assign hat_moved = cur_rep.hat != prev_rep.hat;
   assign new_dy    = hat_dy(cur_rep.hat);
   assign new_dx    = hat_dx(cur_rep.hat);

   always_comb begin
      result.evt.control_id = idx;
      if (idx < IdStickBase) begin
         result.changed       = cur_rep.buttons[btn_sel] != prev_rep.buttons[btn_sel];
         result.evt.is_axis   = 1'b0;
         result.evt.value     = {{(AxisWidth-1){1'b0}}, cur_rep.buttons[btn_sel]};
      end else if (idx < IdHatDy) begin
         result.changed       = new_stick != old_stick;
         result.evt.is_axis   = 1'b1;
         result.evt.value     = new_stick ^ StickCentre;
      end else if (idx == IdHatDy) begin
         result.changed       = hat_moved && (hat_dy(prev_rep.hat) != new_dy);
         result.evt.is_axis   = 1'b1;
         result.evt.value     = new_dy;
      end else begin
         result.changed       = hat_moved && (hat_dx(prev_rep.hat) != new_dx);
         result.evt.is_axis   = 1'b1;
         result.evt.value     = new_dx;
      end
   end

endmodule
`default_nettype wire

// ----- design/gprce_seq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Gamepad report change events: scan sequencer
// Steps the compare unit over all controls, holds the latest event back by one
// so that the final event of a report can be marked, and drives the output
// register.
// ----------------------------------------------------------------------------
module gprce_seq (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid,
   output gprce_pkg::rsp_event_type           rsp_evt,
   output logic [gprce_pkg::IdWidth-1:0]      idx,
   input  gprce_pkg::cmp_result_type          cmp,
   output gprce_pkg::seq_ctrl_type            ctrl
);
   import gprce_pkg::*;

   seq_state_type      state_ff, state_in;
   logic [IdWidth-1:0] idx_ff, idx_in;
   logic               pend_valid_ff, pend_valid_in;
   event_type          pend_evt_ff, pend_evt_in;
   logic               out_valid_ff, out_valid_in;
   rsp_event_type      out_evt_ff, out_evt_in;

   logic out_free;
   logic advance;
   logic push;
   logic push_last;

   assign out_free = !out_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_valid) state_in = SEQ_SCAN;
         end
         SEQ_SCAN: begin
            if (advance && idx_ff == IdLast) state_in = SEQ_FLUSH;
         end
         SEQ_FLUSH: begin
            if (!pend_valid_ff || out_free) state_in = SEQ_IDLE;
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_ready   = 1'b0;
      advance     = 1'b0;
      push        = 1'b0;
      push_last   = 1'b0;
      ctrl.load   = 1'b0;
      ctrl.commit = 1'b0;
      unique case (state_ff)
         SEQ_IDLE: begin
            req_ready = 1'b1;
            ctrl.load = req_valid;
         end
         SEQ_SCAN: begin
            // A new change may only displace the held event if it can leave.
            advance = !cmp.changed || !pend_valid_ff || out_free;
            push    = advance && cmp.changed && pend_valid_ff;
         end
         SEQ_FLUSH: begin
            push        = pend_valid_ff && out_free;
            push_last   = 1'b1;
            ctrl.commit = !pend_valid_ff || out_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      idx_in        = idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_evt_in   = pend_evt_ff;
      out_valid_in  = out_valid_ff;
      out_evt_in    = out_evt_ff;
      if (ctrl.load) begin
         idx_in = '0;
      end else if (advance) begin
         idx_in = idx_ff + IdWidth'(1);
      end
      if (advance && cmp.changed) begin
         pend_valid_in = 1'b1;
         pend_evt_in   = cmp.evt;
      end else if (push) begin
         pend_valid_in = 1'b0;
      end
      if (push) begin
         out_valid_in    = 1'b1;
         out_evt_in.evt  = pend_evt_ff;
         out_evt_in.last = push_last;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SEQ_IDLE;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      pend_evt_ff <= pend_evt_in;
      out_evt_ff  <= out_evt_in;
   end

   assign idx       = idx_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_evt   = out_evt_ff;

`ifndef SYNTH
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == SEQ_IDLE |-> !pend_valid_ff)
      else $error("held event left over after a report finished");

   a_scan_index_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == SEQ_SCAN |-> idx_ff <= IdLast)
      else $error("scan index beyond the last control");

   a_commit_to_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.commit |=> state_ff == SEQ_IDLE)
      else $error("report committed but sequencer not idle");

   a_last_from_flush: assert property (@(posedge clock) disable iff (reset)
      push && push_last |-> state_ff == SEQ_FLUSH && pend_valid_ff)
      else $error("final event issued outside the flush step");
`endif

endmodule
`default_nettype wire

// ----- design/gamepad_report_change_events.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Gamepad report change events
// Compares each incoming report with the previous one and issues one event per
// changed control: buttons, then sticks, then hat components.
// ----------------------------------------------------------------------------
// Flow: a report is accepted, the shared compare unit steps over all 20 controls,
//   then a flush step ends the report; only then is the next report accepted.
// Events: an event leaves once the next change is found or the scan ends;
//   output back-pressure stretches the scan.
// Reset: synchronous; the kept report becomes all released, sticks centered.
module gamepad_report_change_events (
   input  wire logic   clock,
   input  wire logic   reset,
   gprce_req_if.sink   req_ch,
   gprce_rsp_if.source rsp_ch
);
   import gprce_pkg::*;

   report_type     cur_ff, cur_in;
   report_type     prev_ff, prev_in;
   logic [IdWidth-1:0] idx;
   cmp_result_type cmp;
   seq_ctrl_type   ctrl;
   rsp_event_type  rsp_evt;

   always_comb begin
      cur_in  = cur_ff;
      prev_in = prev_ff;
      if (ctrl.load) begin
         cur_in.buttons   = req_ch.buttons;
         cur_in.sticks[0] = req_ch.left_x;
         cur_in.sticks[1] = req_ch.left_y;
         cur_in.sticks[2] = req_ch.right_x;
         cur_in.sticks[3] = req_ch.right_y;
         cur_in.hat       = req_ch.hat_position;
      end
      if (ctrl.commit) begin
         prev_in = cur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff.buttons <= '0;
         prev_ff.sticks  <= {NumSticks{StickCentre}};
         prev_ff.hat     <= HatReleased;
      end else begin
         prev_ff <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff.buttons <= '0;
         cur_ff.sticks  <= {NumSticks{StickCentre}};
         cur_ff.hat     <= HatReleased;
      end else begin
         cur_ff <= cur_in;
      end
   end

   gprce_cmp u_cmp (
      .idx      (idx),
      .prev_rep (prev_ff),
      .cur_rep  (cur_ff),
      .result   (cmp)
   );

   gprce_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_evt   (rsp_evt),
      .idx       (idx),
      .cmp       (cmp),
      .ctrl      (ctrl)
   );

   assign rsp_ch.control_id = rsp_evt.evt.control_id;
   assign rsp_ch.is_axis    = rsp_evt.evt.is_axis;
   assign rsp_ch.value      = rsp_evt.evt.value;
   assign rsp_ch.last       = rsp_evt.last;

`ifndef SYNTH
   a_load_only_when_ready: assert property (@(posedge clock) disable iff (reset)
      ctrl.load |-> req_ch.ready)
      else $error("report loaded while not ready");

   a_kept_report_steady: assert property (@(posedge clock) disable iff (reset)
      !$past(ctrl.commit) && !$past(reset) |-> $stable(prev_ff))
      else $error("kept report changed without a commit");

   a_current_report_steady: assert property (@(posedge clock) disable iff (reset)
      !$past(ctrl.load) && !$past(reset) |-> $stable(cur_ff))
      else $error("current report changed during a scan");
`endif

endmodule
`default_nettype wire

// ----- tb/gprce_event_check.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Gamepad report change events: event checker
// Watches both channels. On every accepted report it works out the change
// events that report must cause and queues them. It then compares every
// accepted event, field by field, with the oldest queued one.
// ----------------------------------------------------------------------------
module gprce_event_check
   import gprce_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   gprce_req_if      req_ch,
   gprce_rsp_if      rsp_ch,
   output int        mismatch_count,
   output int        events_outstanding,
   output int        events_checked
);

   logic [NumButtons-1:0] kept_buttons;
   logic [AxisWidth-1:0]  kept_sticks [NumSticks];
   logic [HatWidth-1:0]   kept_hat;
   rsp_event_type         due_events [$];

   function automatic int hat_vertical(input logic [HatWidth-1:0] code);
      int dir;
      case (code) inside
         HatUp, HatUpRight, HatUpLeft:       dir = -1;
         HatDownRight, HatDown, HatDownLeft: dir = 1;
         default:                            dir = 0;
      endcase
      return dir;
   endfunction

   function automatic int hat_horizontal(input logic [HatWidth-1:0] code);
      int dir;
      case (code) inside
         HatUpRight, HatRight, HatDownRight: dir = 1;
         HatDownLeft, HatLeft, HatUpLeft:    dir = -1;
         default:                            dir = 0;
      endcase
      return dir;
   endfunction

   function automatic rsp_event_type make_event(input int id, input bit axis, input int val);
      rsp_event_type e;
      e.evt.control_id = IdWidth'(id);
      e.evt.is_axis    = axis;
      e.evt.value      = AxisWidth'(val);
      e.last           = 1'b0;
      return e;
   endfunction

   // Queues the events of one report and makes it the kept report.
   function automatic void derive_change_events();
      rsp_event_type        batch [$];
      rsp_event_type        e;
      logic [AxisWidth-1:0] sticks [NumSticks];
      logic [HatWidth-1:0]  hat;
      hat       = req_ch.hat_position;
      sticks[0] = req_ch.left_x;
      sticks[1] = req_ch.left_y;
      sticks[2] = req_ch.right_x;
      sticks[3] = req_ch.right_y;
      for (int i = 0; i < NumButtons; i++) begin
         if (req_ch.buttons[i] != kept_buttons[i])
            batch = {batch, make_event(i, 1'b0, int'(req_ch.buttons[i]))};
      end
      for (int i = 0; i < NumSticks; i++) begin
         if (sticks[i] != kept_sticks[i])
            batch = {batch, make_event(int'(IdStickBase) + i, 1'b1,
                                       int'(sticks[i] ^ StickCentre))};
      end
      // A new hat code alone is not enough: a decoded component must move too.
      if (hat != kept_hat) begin
         if (hat_vertical(hat) != hat_vertical(kept_hat))
            batch = {batch, make_event(int'(IdHatDy), 1'b1, hat_vertical(hat))};
         if (hat_horizontal(hat) != hat_horizontal(kept_hat))
            batch = {batch, make_event(int'(IdHatDx), 1'b1, hat_horizontal(hat))};
      end
      foreach (batch[k]) begin
         e          = batch[k];
         e.last     = (k == batch.size() - 1);
         due_events = {due_events, e};
      end
      kept_buttons = req_ch.buttons;
      kept_hat     = hat;
      for (int i = 0; i < NumSticks; i++) kept_sticks[i] = sticks[i];
   endfunction

   always @(posedge clock) begin : watch
      int            errs;
      rsp_event_type want;
      errs = 0;
      if (reset) begin
         kept_buttons = '0;
         kept_hat     = HatReleased;
         for (int i = 0; i < NumSticks; i++) kept_sticks[i] = StickCentre;
         due_events.delete();
         mismatch_count <= 0;
         events_checked <= 0;
      end else begin
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (due_events.size() == 0) begin
               $error("event with nothing expected: control_id %0d, value %0d",
                      rsp_ch.control_id, rsp_ch.value);
               errs++;
            end else begin
               want = due_events.pop_front();
               if (rsp_ch.control_id !== want.evt.control_id) begin
                  $error("control_id mismatch: expected %0d, got %0d",
                         want.evt.control_id, rsp_ch.control_id);
                  errs++;
               end
               if (rsp_ch.is_axis !== want.evt.is_axis) begin
                  $error("is_axis mismatch: expected %0d, got %0d",
                         want.evt.is_axis, rsp_ch.is_axis);
                  errs++;
               end
               if (rsp_ch.value !== want.evt.value) begin
                  $error("value mismatch: expected %0d, got %0d",
                         want.evt.value, rsp_ch.value);
                  errs++;
               end
               if (rsp_ch.last !== want.last) begin
                  $error("last mismatch: expected %0d, got %0d",
                         want.last, rsp_ch.last);
                  errs++;
               end
            end
            events_checked <= events_checked + 1;
         end
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) derive_change_events();
         mismatch_count <= mismatch_count + errs;
      end
      events_outstanding <= due_events.size();
   end

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Gamepad report change events: testbench top
// Sends a directed set of reports (all hat codes, button and stick extremes,
// unchanged reports), then a few hundred random ones, with random gaps on the
// report side and random stalls on the event side. Checking is done by the
// event checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
   import gprce_pkg::*;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   events_outstanding;
   int   events_checked;
   int   reports_sent;
   bit   steady;

   gprce_req_if req_ch ();
   gprce_rsp_if rsp_ch ();

   gamepad_report_change_events DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   gprce_event_check event_check (
      .clock              (clock),
      .reset              (reset),
      .req_ch             (req_ch),
      .rsp_ch             (rsp_ch),
      .mismatch_count     (mismatch_count),
      .events_outstanding (events_outstanding),
      .events_checked     (events_checked)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("FAIL");
      $finish;
   end

   function automatic report_type make_report(input logic [NumButtons-1:0] buttons,
                                              input logic [AxisWidth-1:0] lx,
                                              input logic [AxisWidth-1:0] ly,
                                              input logic [AxisWidth-1:0] rx,
                                              input logic [AxisWidth-1:0] ry,
                                              input logic [HatWidth-1:0] hat);
      report_type rpt;
      rpt.buttons   = buttons;
      rpt.sticks[0] = lx;
      rpt.sticks[1] = ly;
      rpt.sticks[2] = rx;
      rpt.sticks[3] = ry;
      rpt.hat       = hat;
      return rpt;
   endfunction

   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Mostly small edits of the previous report, some unchanged, some wholly new.
   function automatic report_type next_report(input report_type prev);
      report_type rpt;
      int         mode;
      rpt  = prev;
      mode = $urandom_range(0, 99);
      if (mode < 15) begin
         rpt = prev;
      end else if (mode < 55) begin
         repeat ($urandom_range(1, 3)) rpt.buttons[$urandom_range(0, NumButtons-1)] ^= 1'b1;
         if ($urandom_range(0, 1) == 1) rpt.sticks[$urandom_range(0, NumSticks-1)] = 8'($urandom);
         if ($urandom_range(0, 2) == 0) rpt.hat = 4'($urandom_range(0, 8));
      end else if (mode < 80) begin
         rpt.buttons = NumButtons'($urandom);
         for (int i = 0; i < NumSticks; i++) rpt.sticks[i] = 8'($urandom);
         rpt.hat = 4'($urandom);
      end else begin
         rpt.hat = 4'($urandom_range(0, 15));
         case ($urandom_range(0, 3))
            0:       rpt.sticks[$urandom_range(0, NumSticks-1)] = 8'h00;
            1:       rpt.sticks[$urandom_range(0, NumSticks-1)] = 8'hFF;
            2:       rpt.sticks[$urandom_range(0, NumSticks-1)] = 8'h7F;
            default: rpt.sticks[$urandom_range(0, NumSticks-1)] = StickCentre;
         endcase
      end
      return rpt;
   endfunction

   task automatic send_report(input report_type rpt);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.buttons      <= rpt.buttons;
      req_ch.left_x       <= rpt.sticks[0];
      req_ch.left_y       <= rpt.sticks[1];
      req_ch.right_x      <= rpt.sticks[2];
      req_ch.right_y      <= rpt.sticks[3];
      req_ch.hat_position <= rpt.hat;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      reports_sent++;
   endtask

   task automatic wait_all_events();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (events_outstanding != 0);
   endtask

   // Event side: mostly ready, short stalls, now and then a long stall or a
   // long run without any stall.
   initial begin
      int r;
      rsp_ch.ready <= 1'b0;
      forever begin
         r = $urandom_range(0, 99);
         if (r < 5) begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(100, 200)) @(posedge clock);
         end else if (r < 60) begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end else if (r < 92) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(10, 40)) @(posedge clock);
         end
      end
   end

   initial begin
      report_type directed [$];
      report_type rpt;
      int         n_directed;
      reports_sent        = 0;
      steady              = 1'b0;
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.buttons      <= '0;
      req_ch.left_x       <= StickCentre;
      req_ch.left_y       <= StickCentre;
      req_ch.right_x      <= StickCentre;
      req_ch.right_y      <= StickCentre;
      req_ch.hat_position <= HatReleased;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Same as the kept report after reset: no events at all.
      directed = {directed, make_report(14'h0000, 8'd128, 8'd128, 8'd128, 8'd128, HatReleased)};
      // Every button, the left stick to its extremes, the right stick just off centre, hat up.
      directed = {directed, make_report(14'h3FFF, 8'd0, 8'd255, 8'd127, 8'd129, HatUp)};
      // Everything changes, both hat components too: the longest event burst.
      directed = {directed, make_report(14'h0000, 8'd255, 8'd0, 8'd0, 8'd255, HatDownRight)};
      directed = {directed, make_report(14'h0000, 8'd255, 8'd0, 8'd0, 8'd255, HatDownRight)};
      // Unused hat codes decode as released.
      directed = {directed, make_report(14'h2AAA, 8'd255, 8'd0, 8'd0, 8'd255, 4'd9)};
      directed = {directed, make_report(14'h1555, 8'd128, 8'd128, 8'd128, 8'd128, 4'd15)};
      directed = {directed, make_report(14'h1555, 8'd128, 8'd128, 8'd128, 8'd128, HatReleased)};
      // Walk the hat so each component changes on its own.
      directed = {directed, make_report(14'h1555, 8'd128, 8'd128, 8'd128, 8'd128, HatRight)};
      directed = {directed, make_report(14'h1555, 8'd128, 8'd128, 8'd128, 8'd128, HatUpRight)};
      directed = {directed, make_report(14'h1555, 8'd128, 8'd128, 8'd128, 8'd128, HatUpLeft)};
      directed = {directed, make_report(14'h1555, 8'd128, 8'd128, 8'd128, 8'd128, HatLeft)};
      directed = {directed, make_report(14'h1555, 8'd128, 8'd128, 8'd128, 8'd128, HatDownLeft)};
      directed = {directed, make_report(14'h1555, 8'd128, 8'd128, 8'd128, 8'd128, HatDown)};
      directed = {directed, make_report(14'h1555, 8'd128, 8'd128, 8'd128, 8'd128, 4'd10)};
      directed = {directed, make_report(14'h1555, 8'd128, 8'd128, 8'd128, 8'd128, 4'd11)};
      directed = {directed, make_report(14'h1555, 8'd128, 8'd128, 8'd128, 8'd128, 4'd12)};
      directed = {directed, make_report(14'h1555, 8'd128, 8'd128, 8'd128, 8'd128, 4'd13)};
      directed = {directed, make_report(14'h1555, 8'd128, 8'd128, 8'd128, 8'd128, 4'd14)};
      directed = {directed, make_report(14'h0001, 8'd127, 8'd128, 8'd128, 8'd128, 4'd14)};
      directed = {directed, make_report(14'h2000, 8'd127, 8'd128, 8'd128, 8'd129, 4'd14)};
      directed = {directed, make_report(14'h2000, 8'd127, 8'd128, 8'd128, 8'd129, HatUp)};
      foreach (directed[k]) send_report(directed[k]);
      n_directed = reports_sent;

      // The sender holds off here until every pending event has left.
      wait_all_events();

      rpt = directed[directed.size()-1];
      for (int n = 0; n < 260; n++) begin
         steady = (n >= 60 && n < 100);
         if (n == 150) wait_all_events();
         rpt = next_report(rpt);
         send_report(rpt);
      end
      wait_all_events();
      repeat (60) @(posedge clock);

      $display("Sent %0d reports (%0d directed, the rest random) and checked %0d events.",
               reports_sent, n_directed, events_checked);
      $display("Covered every hat code, button and stick extremes, and unchanged reports.");
      if (mismatch_count == 0 && events_outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
